// File: sv/ptcc_pkg.sv
// ptcc_pkg: shared constants, codes and types for the pan/tilt command coalescer.
// No dependencies; imported by the interfaces, the axis lanes, the merge stage and the top level.
package ptcc_pkg;

   localparam int PRESET_SLOTS = 8;

   localparam int CMD_W      = 3;
   localparam int DELTA_W    = 16;
   localparam int SLOT_W     = 4;
   localparam int MODE_W     = 5;
   localparam int VAL_W      = 16;
   localparam int REG_W      = 16;
   localparam int CSR_IDX_W  = 3;
   localparam int SUM_W      = 24;
   localparam int CNT_W      = 16;
   localparam int RANGE_W    = REG_W + 1;
   localparam int NORM_W     = SUM_W + RANGE_W;
   localparam int PROD_W     = NORM_W + RANGE_W;
   localparam int FRAC_SHIFT = 24;
   localparam int QUOT_W     = PROD_W - FRAC_SHIFT;

   // request codes
   localparam logic [CMD_W-1:0] CMD_TICK   = 3'd0;
   localparam logic [CMD_W-1:0] CMD_MOVE   = 3'd1;
   localparam logic [CMD_W-1:0] CMD_HOME   = 3'd2;
   localparam logic [CMD_W-1:0] CMD_SAVE   = 3'd3;
   localparam logic [CMD_W-1:0] CMD_RECALL = 3'd4;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INVERSE   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PAN_LOW   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_PAN_HIGH  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_TILT_LOW  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_TILT_HIGH = 3'd5;

   localparam logic [REG_W-1:0] WINDOW_RESET  = 16'd700;
   localparam logic [REG_W-1:0] INVERSE_RESET = 16'd5851;

   localparam logic [MODE_W-1:0] MODE_NONE        = 5'd0;
   localparam logic [MODE_W-1:0] MODE_HOME        = 5'd3;
   localparam logic [MODE_W-1:0] MODE_SAVE_BASE   = 5'd4;
   localparam logic [MODE_W-1:0] MODE_RECALL_BASE = 5'd12;

   localparam logic KIND_REL  = 1'b0;
   localparam logic KIND_MODE = 1'b1;

   localparam logic signed [SUM_W:0] SUM_MAX = {2'b00, {(SUM_W-1){1'b1}}};
   localparam logic signed [SUM_W:0] SUM_MIN = {2'b11, {(SUM_W-1){1'b0}}};

   localparam logic [CNT_W-1:0] CNT_MAX = '1;

   typedef struct packed {
      logic load;    // add the request deltas
      logic stale;   // drop the old sum before adding
      logic clear;   // zero the pending sum
      logic norm;    // capture sum times inverse window
      logic prod;    // capture norm times axis range
   } lane_ctrl_type;

   typedef struct packed {
      logic              accepted;
      logic              sent;
      logic              kind;
      logic [MODE_W-1:0] mode;
   } res_info_type;

endpackage

// File: sv/ptcc_if.sv
// ptcc request and response channel interfaces with valid/ready handshake.
// Depends on ptcc_pkg for field widths.
interface ptcc_req_if import ptcc_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic [CMD_W-1:0]          cmd;
   logic signed [DELTA_W-1:0] pan_delta;
   logic signed [DELTA_W-1:0] tilt_delta;
   logic [SLOT_W-1:0]         preset_slot;

   modport source (output valid, cmd, pan_delta, tilt_delta, preset_slot, input ready);
   modport sink   (input valid, cmd, pan_delta, tilt_delta, preset_slot, output ready);
endinterface

interface ptcc_rsp_if import ptcc_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic                    accepted;
   logic                    command_sent;
   logic                    command_kind;
   logic [MODE_W-1:0]       mode_byte;
   logic signed [VAL_W-1:0] pan_command;
   logic signed [VAL_W-1:0] tilt_command;

   modport source (output valid, accepted, command_sent, command_kind, mode_byte,
                   pan_command, tilt_command, input ready);
   modport sink   (input valid, accepted, command_sent, command_kind, mode_byte,
                   pan_command, tilt_command, output ready);
endinterface

// File: sv/pan_tilt_command_coalescer.sv
// Pan/tilt command coalescer: a tick is taken with no response; home and preset go from idle
// to the output step; a move passes the decide and, with a command, the product step (norm,
// then product multiply, in each axis lane). The next transaction is taken once the response
// sits in the output register; a stalled response holds the sequencer in its output step.
// Synchronous active-high reset: pending sums zero, both tick counters saturated,
// registers at their defaults (window 700, inverse window 5851, limits 0).
module pan_tilt_command_coalescer import ptcc_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [REG_W-1:0]     csr_wdata,
   ptcc_req_if.sink             req_ch,
   ptcc_rsp_if.source           rsp_ch
);

   typedef enum logic [1:0] {ST_IDLE, ST_DECIDE, ST_PROD, ST_OUT} state_type;

   state_type             state_ff;
   res_info_type          info_ff;
   logic [REG_W-1:0]      window_ff, inverse_ff;
   logic signed [REG_W-1:0] pan_low_ff, pan_high_ff, tilt_low_ff, tilt_high_ff;
   logic [CNT_W-1:0]      tsr_ff, tsc_ff;

   logic                  accept, emit, slot_ok, out_free, pan_zero, tilt_zero;
   logic [MODE_W-1:0]     preset_mode;
   lane_ctrl_type         lane_ctrl;
   logic signed [VAL_W-1:0] pan_value, tilt_value;

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign accept       = req_ch.valid && req_ch.ready;

   assign emit = (state_ff == ST_DECIDE) && (tsc_ff >= window_ff) && !(pan_zero && tilt_zero);

   assign slot_ok = (req_ch.preset_slot != '0) &&
                    (req_ch.preset_slot <= SLOT_W'(PRESET_SLOTS));
   assign preset_mode = ((req_ch.cmd == CMD_SAVE) ? MODE_SAVE_BASE : MODE_RECALL_BASE)
                        + MODE_W'(req_ch.preset_slot) - MODE_W'(1);

   always_comb begin
      lane_ctrl.load  = accept && (req_ch.cmd == CMD_MOVE);
      lane_ctrl.stale = (tsr_ff > window_ff);
      lane_ctrl.clear = (accept && (req_ch.cmd == CMD_HOME)) || emit;
      lane_ctrl.norm  = emit;
      lane_ctrl.prod  = (state_ff == ST_PROD);
   end

   ptcc_axis_lane u_pan_lane (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (lane_ctrl),
      .delta      (req_ch.pan_delta),
      .inv_window (inverse_ff),
      .low        (pan_low_ff),
      .high       (pan_high_ff),
      .sum_zero   (pan_zero),
      .value      (pan_value)
   );

   ptcc_axis_lane u_tilt_lane (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (lane_ctrl),
      .delta      (req_ch.tilt_delta),
      .inv_window (inverse_ff),
      .low        (tilt_low_ff),
      .high       (tilt_high_ff),
      .sum_zero   (tilt_zero),
      .value      (tilt_value)
   );

   ptcc_merge u_merge (
      .clock      (clock),
      .reset      (reset),
      .load       ((state_ff == ST_OUT) && out_free),
      .info       (info_ff),
      .pan_value  (pan_value),
      .tilt_value (tilt_value),
      .free       (out_free),
      .rsp_ch     (rsp_ch)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  unique case (req_ch.cmd) inside
                     CMD_MOVE: state_ff <= ST_DECIDE;
                     CMD_HOME: begin
                        info_ff  <= '{accepted: 1'b1, sent: 1'b1, kind: KIND_MODE,
                                      mode: MODE_HOME};
                        state_ff <= ST_OUT;
                     end
                     CMD_SAVE, CMD_RECALL: begin
                        if (slot_ok) begin
                           info_ff <= '{accepted: 1'b1, sent: 1'b1, kind: KIND_MODE,
                                        mode: preset_mode};
                        end else begin
                           info_ff <= '{accepted: 1'b0, sent: 1'b0, kind: KIND_REL,
                                        mode: MODE_NONE};
                        end
                        state_ff <= ST_OUT;
                     end
                     default: state_ff <= ST_IDLE;   // tick and unused codes
                  endcase
               end
            end
            ST_DECIDE: begin
               info_ff  <= '{accepted: 1'b1, sent: emit, kind: KIND_REL, mode: MODE_NONE};
               state_ff <= emit ? ST_PROD : ST_OUT;
            end
            ST_PROD: state_ff <= ST_OUT;
            ST_OUT: begin
               if (out_free) state_ff <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   // saturating tick counters
   always_ff @(posedge clock) begin
      if (reset) begin
         tsr_ff <= CNT_MAX;
         tsc_ff <= CNT_MAX;
      end else begin
         if (accept && (req_ch.cmd == CMD_TICK)) begin
            if (tsr_ff != CNT_MAX) tsr_ff <= tsr_ff + CNT_W'(1);
            if (tsc_ff != CNT_MAX) tsc_ff <= tsc_ff + CNT_W'(1);
         end
         if (accept && (req_ch.cmd == CMD_MOVE)) tsr_ff <= '0;
         if (emit) tsc_ff <= '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff    <= WINDOW_RESET;
         inverse_ff   <= INVERSE_RESET;
         pan_low_ff   <= '0;
         pan_high_ff  <= '0;
         tilt_low_ff  <= '0;
         tilt_high_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_WINDOW:    window_ff    <= csr_wdata;
            CSR_INVERSE:   inverse_ff   <= csr_wdata;
            CSR_PAN_LOW:   pan_low_ff   <= csr_wdata;
            CSR_PAN_HIGH:  pan_high_ff  <= csr_wdata;
            CSR_TILT_LOW:  tilt_low_ff  <= csr_wdata;
            CSR_TILT_HIGH: tilt_high_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

endmodule

// File: sv/ptcc_axis_lane.sv
// ptcc_axis_lane: one axis lane; pending sum, two-step scaling and clamp.
// Depends on ptcc_pkg.
module ptcc_axis_lane import ptcc_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  lane_ctrl_type             ctrl,
   input  logic signed [DELTA_W-1:0] delta,
   input  logic [REG_W-1:0]          inv_window,
   input  logic signed [REG_W-1:0]   low,
   input  logic signed [REG_W-1:0]   high,
   output logic                      sum_zero,
   output logic signed [VAL_W-1:0]   value
);

   logic signed [SUM_W-1:0]   sum_ff, sum_in;
   logic signed [SUM_W:0]     base, acc;
   logic signed [NORM_W-1:0]  norm_ff, norm_in;
   logic signed [RANGE_W-1:0] inv_s, range;
   logic signed [PROD_W-1:0]  prod_ff, prod_in, prod_adj;
   logic signed [QUOT_W-1:0]  quot, low_x, high_x, lim;

   always_comb begin
      base = ctrl.stale ? '0 : {sum_ff[SUM_W-1], sum_ff};
      acc  = base + {{(SUM_W+1-DELTA_W){delta[DELTA_W-1]}}, delta};
      sum_in = sum_ff;
      if (ctrl.clear) begin
         sum_in = '0;
      end else if (ctrl.load) begin
         if (acc > SUM_MAX) begin
            sum_in = SUM_MAX[SUM_W-1:0];
         end else if (acc < SUM_MIN) begin
            sum_in = SUM_MIN[SUM_W-1:0];
         end else begin
            sum_in = acc[SUM_W-1:0];
         end
      end

      inv_s   = {1'b0, inv_window};
      norm_in = NORM_W'(sum_ff) * NORM_W'(inv_s);

      // negative scaled value uses the magnitude of the low limit
      range   = norm_ff[NORM_W-1] ? -{low[REG_W-1], low} : {high[REG_W-1], high};
      prod_in = PROD_W'(norm_ff) * PROD_W'(range);

      // truncate toward zero on the divide by 2^24
      prod_adj = prod_ff[PROD_W-1] ? prod_ff + PROD_W'((1 << FRAC_SHIFT) - 1) : prod_ff;
      quot     = prod_adj[PROD_W-1:FRAC_SHIFT];

      low_x  = {{(QUOT_W-REG_W){low[REG_W-1]}}, low};
      high_x = {{(QUOT_W-REG_W){high[REG_W-1]}}, high};
      lim = quot;
      if (quot < low_x) lim = low_x;
      if (lim > high_x) lim = high_x;   // high wins over low

      value    = lim[VAL_W-1:0];
      sum_zero = (sum_ff == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff <= '0;
      end else begin
         sum_ff <= sum_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.norm) norm_ff <= norm_in;
      if (ctrl.prod) prod_ff <= prod_in;
   end

endmodule

// File: sv/ptcc_merge.sv
// ptcc_merge: combines the lane values with the result kind into the output register.
// Depends on ptcc_pkg and ptcc_rsp_if.
module ptcc_merge import ptcc_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    load,
   input  res_info_type            info,
   input  logic signed [VAL_W-1:0] pan_value,
   input  logic signed [VAL_W-1:0] tilt_value,
   output logic                    free,
   ptcc_rsp_if.source              rsp_ch
);

   logic                    valid_ff;
   res_info_type            info_ff;
   logic signed [VAL_W-1:0] pan_ff, tilt_ff;
   logic                    rel;

   assign rel  = info.sent && (info.kind == KIND_REL);
   assign free = !valid_ff || rsp_ch.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         info_ff <= info;
         pan_ff  <= rel ? pan_value : '0;
         tilt_ff <= rel ? tilt_value : '0;
      end
   end

   assign rsp_ch.valid        = valid_ff;
   assign rsp_ch.accepted     = info_ff.accepted;
   assign rsp_ch.command_sent = info_ff.sent;
   assign rsp_ch.command_kind = info_ff.kind;
   assign rsp_ch.mode_byte    = info_ff.mode;
   assign rsp_ch.pan_command  = pan_ff;
   assign rsp_ch.tilt_command = tilt_ff;

endmodule
